// File: hw/rtl/ilfb_pkg.sv
// ilfb_pkg: shared types, constants, crc step and microcode rom of the ir label frame builder
// used by ilfb_seq and ir_label_frame_builder; no dependencies
package ilfb_pkg;

  localparam int DATA_BYTES_DEF   = 20;
  localparam int BITMAP_BYTES_DEF = 23;

  localparam int PC_W      = 7;
  localparam int REP_W     = 5;
  localparam int CFG_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_ID = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SUB = 4'd3;

  localparam logic [31:0] LABEL_ID_RST  = 32'h0000_0000;
  localparam logic [15:0] CRC_INIT_RST  = 16'h8408;
  localparam logic [15:0] CRC_POLY_RST  = 16'h8408;
  localparam logic [7:0]  DATA_SUB_RST  = 8'h20;

  // item commands
  localparam logic [2:0] CMD_WAKE    = 3'd0;
  localparam logic [2:0] CMD_REFRESH = 3'd1;
  localparam logic [2:0] CMD_PARAMS  = 3'd2;
  localparam logic [2:0] CMD_DATA    = 3'd3;
  localparam logic [2:0] CMD_SEGMENT = 3'd4;

  // wire bytes
  localparam logic [7:0] B_PROTO_MCU = 8'h85;
  localparam logic [7:0] B_PROTO_SEG = 8'h84;
  localparam logic [7:0] B_OP_WAKE   = 8'h17;
  localparam logic [7:0] B_OP_MCU    = 8'h34;
  localparam logic [7:0] B_OP_SEG    = 8'hBA;
  localparam logic [7:0] B_SUB_REF   = 8'h01;
  localparam logic [7:0] B_SUB_PAR   = 8'h05;
  localparam logic [7:0] B_ONE       = 8'h01;
  localparam logic [7:0] B_ZERO      = 8'h00;
  localparam logic [7:0] B_PAR_MARK  = 8'h88;
  localparam logic [7:0] B_TRL_A     = 8'h09;
  localparam logic [7:0] B_TRL_B     = 8'h10;
  localparam logic [7:0] B_TRL_C     = 8'h31;

  typedef enum logic [4:0] {
    SRC_CONST,
    SRC_LID0,
    SRC_LID1,
    SRC_LID2,
    SRC_LID3,
    SRC_SUB,
    SRC_TOT_HI,
    SRC_TOT_LO,
    SRC_COMP,
    SRC_PAGE,
    SRC_W_HI,
    SRC_W_LO,
    SRC_H_HI,
    SRC_H_LO,
    SRC_FN_HI,
    SRC_FN_LO,
    SRC_PAY,
    SRC_BCRC_LO,
    SRC_BCRC_HI,
    SRC_FCRC_LO,
    SRC_FCRC_HI
  } src_t;

  typedef enum logic [2:0] {
    FLOW_NEXT,
    FLOW_JUMP,
    FLOW_FIN,
    FLOW_FIN_IF_MORE,
    FLOW_JUMP_IF_DATA
  } flow_t;

  typedef struct packed {
    src_t             src;
    logic [7:0]       konst;
    logic [REP_W-1:0] rep;
    logic             crc;
    logic             pay;
    logic             pad;
    logic             last;
    logic             close;
    flow_t            flow;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic end_flag;
    logic is_data;
    logic room;
    logic out_free;
  } seq_cond_t;

  typedef struct packed {
    logic   busy;
    logic   emit;
    ucode_t word;
  } seq_ctl_t;

  // program entry points
  localparam logic [PC_W-1:0] A_WAKE = 7'd0;
  localparam logic [PC_W-1:0] A_REF  = 7'd9;
  localparam logic [PC_W-1:0] A_PAR  = 7'd18;
  localparam logic [PC_W-1:0] A_DHDR = 7'd38;
  localparam logic [PC_W-1:0] A_SHDR = 7'd48;
  localparam logic [PC_W-1:0] A_PAY  = 7'd55;
  localparam logic [PC_W-1:0] A_PAD  = 7'd56;
  localparam logic [PC_W-1:0] A_TAIL = 7'd65;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic ucode_t uc(input src_t s, input logic [7:0] k,
                                input logic [REP_W-1:0] rep, input flow_t f,
                                input logic [PC_W-1:0] t);
    ucode_t w;
    w.src    = s;
    w.konst  = k;
    w.rep    = rep;
    w.crc    = 1'b1;
    w.pay    = 1'b0;
    w.pad    = 1'b0;
    w.last   = 1'b0;
    w.close  = 1'b0;
    w.flow   = f;
    w.target = t;
    return w;
  endfunction

  // rep holds the repeat count minus one
  function automatic ucode_t rom(input logic [PC_W-1:0] a);
    ucode_t w;
    w = uc(SRC_CONST, B_ZERO, 5'd0, FLOW_FIN, A_WAKE);
    case (a)
      // wake
      A_WAKE:         w = uc(SRC_CONST, B_PROTO_MCU, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd1:  w = uc(SRC_LID0, B_ZERO, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd2:  w = uc(SRC_LID1, B_ZERO, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd3:  w = uc(SRC_LID2, B_ZERO, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd4:  w = uc(SRC_LID3, B_ZERO, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd5:  w = uc(SRC_CONST, B_OP_WAKE, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd6:  w = uc(SRC_CONST, B_ONE, 5'd0, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd7:  w = uc(SRC_CONST, B_ZERO, 5'd2, FLOW_NEXT, A_WAKE);
      A_WAKE + 7'd8:  w = uc(SRC_CONST, B_ONE, 5'd21, FLOW_JUMP, A_TAIL);
      // refresh
      A_REF:          w = uc(SRC_CONST, B_PROTO_MCU, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd1:   w = uc(SRC_LID0, B_ZERO, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd2:   w = uc(SRC_LID1, B_ZERO, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd3:   w = uc(SRC_LID2, B_ZERO, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd4:   w = uc(SRC_LID3, B_ZERO, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd5:   w = uc(SRC_CONST, B_OP_MCU, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd6:   w = uc(SRC_CONST, B_ZERO, 5'd2, FLOW_NEXT, A_REF);
      A_REF + 7'd7:   w = uc(SRC_CONST, B_SUB_REF, 5'd0, FLOW_NEXT, A_REF);
      A_REF + 7'd8:   w = uc(SRC_CONST, B_ZERO, 5'd21, FLOW_JUMP, A_TAIL);
      // params
      A_PAR:          w = uc(SRC_CONST, B_PROTO_MCU, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd1:   w = uc(SRC_LID0, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd2:   w = uc(SRC_LID1, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd3:   w = uc(SRC_LID2, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd4:   w = uc(SRC_LID3, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd5:   w = uc(SRC_CONST, B_OP_MCU, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd6:   w = uc(SRC_CONST, B_ZERO, 5'd2, FLOW_NEXT, A_PAR);
      A_PAR + 7'd7:   w = uc(SRC_CONST, B_SUB_PAR, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd8:   w = uc(SRC_TOT_HI, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd9:   w = uc(SRC_TOT_LO, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd10:  w = uc(SRC_CONST, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd11:  w = uc(SRC_COMP, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd12:  w = uc(SRC_PAGE, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd13:  w = uc(SRC_W_HI, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd14:  w = uc(SRC_W_LO, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd15:  w = uc(SRC_H_HI, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd16:  w = uc(SRC_H_LO, B_ZERO, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd17:  w = uc(SRC_CONST, B_ZERO, 5'd5, FLOW_NEXT, A_PAR);
      A_PAR + 7'd18:  w = uc(SRC_CONST, B_PAR_MARK, 5'd0, FLOW_NEXT, A_PAR);
      A_PAR + 7'd19:  w = uc(SRC_CONST, B_ZERO, 5'd5, FLOW_JUMP, A_TAIL);
      // data frame header
      A_DHDR:         w = uc(SRC_CONST, B_PROTO_MCU, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd1:  w = uc(SRC_LID0, B_ZERO, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd2:  w = uc(SRC_LID1, B_ZERO, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd3:  w = uc(SRC_LID2, B_ZERO, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd4:  w = uc(SRC_LID3, B_ZERO, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd5:  w = uc(SRC_CONST, B_OP_MCU, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd6:  w = uc(SRC_CONST, B_ZERO, 5'd2, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd7:  w = uc(SRC_SUB, B_ZERO, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd8:  w = uc(SRC_FN_HI, B_ZERO, 5'd0, FLOW_NEXT, A_DHDR);
      A_DHDR + 7'd9:  w = uc(SRC_FN_LO, B_ZERO, 5'd0, FLOW_JUMP, A_PAY);
      // segment frame header, falls into the payload step
      A_SHDR:         w = uc(SRC_CONST, B_PROTO_SEG, 5'd0, FLOW_NEXT, A_SHDR);
      A_SHDR + 7'd1:  w = uc(SRC_LID0, B_ZERO, 5'd0, FLOW_NEXT, A_SHDR);
      A_SHDR + 7'd2:  w = uc(SRC_LID1, B_ZERO, 5'd0, FLOW_NEXT, A_SHDR);
      A_SHDR + 7'd3:  w = uc(SRC_LID2, B_ZERO, 5'd0, FLOW_NEXT, A_SHDR);
      A_SHDR + 7'd4:  w = uc(SRC_LID3, B_ZERO, 5'd0, FLOW_NEXT, A_SHDR);
      A_SHDR + 7'd5:  w = uc(SRC_CONST, B_OP_SEG, 5'd0, FLOW_NEXT, A_SHDR);
      A_SHDR + 7'd6:  w = uc(SRC_CONST, B_ZERO, 5'd2, FLOW_NEXT, A_SHDR);
      A_PAY: begin
        w = uc(SRC_PAY, B_ZERO, 5'd0, FLOW_FIN_IF_MORE, A_PAY);
        w.pay = 1'b1;
      end
      A_PAD: begin
        w = uc(SRC_CONST, B_ZERO, 5'd0, FLOW_JUMP_IF_DATA, A_TAIL);
        w.pad = 1'b1;
      end
      // segment trailer
      A_PAD + 7'd1:   w = uc(SRC_BCRC_LO, B_ZERO, 5'd0, FLOW_NEXT, A_PAD);
      A_PAD + 7'd2:   w = uc(SRC_BCRC_HI, B_ZERO, 5'd0, FLOW_NEXT, A_PAD);
      A_PAD + 7'd3:   w = uc(SRC_CONST, B_ZERO, 5'd1, FLOW_NEXT, A_PAD);
      A_PAD + 7'd4:   w = uc(SRC_CONST, B_TRL_A, 5'd0, FLOW_NEXT, A_PAD);
      A_PAD + 7'd5:   w = uc(SRC_CONST, B_ZERO, 5'd0, FLOW_NEXT, A_PAD);
      A_PAD + 7'd6:   w = uc(SRC_CONST, B_TRL_B, 5'd0, FLOW_NEXT, A_PAD);
      A_PAD + 7'd7:   w = uc(SRC_CONST, B_ZERO, 5'd0, FLOW_NEXT, A_PAD);
      A_PAD + 7'd8:   w = uc(SRC_CONST, B_TRL_C, 5'd0, FLOW_NEXT, A_PAD);
      // frame crc, low byte first
      A_TAIL: begin
        w = uc(SRC_FCRC_LO, B_ZERO, 5'd0, FLOW_NEXT, A_TAIL);
        w.crc = 1'b0;
      end
      A_TAIL + 7'd1: begin
        w = uc(SRC_FCRC_HI, B_ZERO, 5'd0, FLOW_FIN, A_TAIL);
        w.crc   = 1'b0;
        w.last  = 1'b1;
        w.close = 1'b1;
      end
      default: w = uc(SRC_CONST, B_ZERO, 5'd0, FLOW_FIN, A_WAKE);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/ilfb_seq.sv
// ilfb_seq: microcode sequencer with program counter, repeat counter and conditional jumps
// depends on ilfb_pkg (control word, rom, condition and control structs)
module ilfb_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ilfb_pkg::PC_W-1:0]     entry,
  input  ilfb_pkg::seq_cond_t           cond,
  output ilfb_pkg::seq_ctl_t            ctl
);

  logic                           busy;
  logic                           busy_next;
  logic [ilfb_pkg::PC_W-1:0]      pc;
  logic [ilfb_pkg::PC_W-1:0]      pc_next;
  logic [ilfb_pkg::REP_W-1:0]     cnt;
  logic [ilfb_pkg::REP_W-1:0]     cnt_next;
  ilfb_pkg::ucode_t               word;
  logic                           need_out;
  logic                           emit;
  logic                           hold;

  always_comb begin
    word      = ilfb_pkg::rom(pc);
    need_out  = !((word.pay || word.pad) && !cond.room);
    emit      = busy && need_out && cond.out_free;
    hold      = (need_out && !cond.out_free) || (emit && (word.pad || cnt != word.rep));
    busy_next = busy;
    pc_next   = pc;
    cnt_next  = cnt;
    if (emit && !word.pad && cnt != word.rep) begin
      cnt_next = cnt + 1'b1;
    end
    if (start) begin
      busy_next = 1'b1;
      pc_next   = entry;
      cnt_next  = '0;
    end else if (busy && !hold) begin
      cnt_next = '0;
      case (word.flow)
        ilfb_pkg::FLOW_NEXT: pc_next = pc + 1'b1;
        ilfb_pkg::FLOW_JUMP: pc_next = word.target;
        ilfb_pkg::FLOW_FIN:  busy_next = 1'b0;
        ilfb_pkg::FLOW_FIN_IF_MORE: begin
          if (cond.end_flag) begin
            pc_next = pc + 1'b1;
          end else begin
            busy_next = 1'b0;
          end
        end
        ilfb_pkg::FLOW_JUMP_IF_DATA: pc_next = cond.is_data ? word.target : pc + 1'b1;
        default: busy_next = 1'b0;
      endcase
    end
    ctl.busy = busy;
    ctl.emit = emit;
    ctl.word = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      cnt  <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
      cnt  <= cnt_next;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= word.rep)
    else $error("repeat counter past its step count");

endmodule

// File: hw/rtl/ir_label_frame_builder.sv
// ir_label_frame_builder: top level, item latch, byte datapath, two crc units, output register
// depends on ilfb_pkg and ilfb_seq
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------------
//  in       | in_valid / in_stall  | cmd, total_count, compression_kind, page_number,
//           |                      | image_width, image_height, frame_number,
//           |                      | payload_byte, payload_end
//  out      | out_valid / out_stall| frame_byte, frame_end
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time: after the accept cycle the microcode step loop emits one byte per cycle
// while the output is free; output stalls hold the loop, the step that ends padding emits no
// byte, and a payload byte past the frame payload size is dropped without output
// reset: synchronous, no clearing pass; in_stall is high while a program runs
module ir_label_frame_builder #(
  parameter int DATA_BYTES   = ilfb_pkg::DATA_BYTES_DEF,
  parameter int BITMAP_BYTES = ilfb_pkg::BITMAP_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       cmd,
  input  logic [15:0]                      total_count,
  input  logic [7:0]                       compression_kind,
  input  logic [7:0]                       page_number,
  input  logic [15:0]                      image_width,
  input  logic [15:0]                      image_height,
  input  logic [15:0]                      frame_number,
  input  logic [7:0]                       payload_byte,
  input  logic                             payload_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       frame_byte,
  output logic                             frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ilfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int MAX_BYTES = (DATA_BYTES > BITMAP_BYTES) ? DATA_BYTES : BITMAP_BYTES;
  localparam int SEEN_W    = $clog2(MAX_BYTES + 1);

  localparam logic [SEEN_W-1:0] DATA_LIMIT   = SEEN_W'(DATA_BYTES);
  localparam logic [SEEN_W-1:0] BITMAP_LIMIT = SEEN_W'(BITMAP_BYTES);

  logic [31:0]        label_id;
  logic [15:0]        crc_init;
  logic [15:0]        crc_polynomial;
  logic [7:0]         data_subcommand;

  logic               in_frame;
  logic               open_seg;
  logic [SEEN_W-1:0]  seen;
  logic [15:0]        frame_crc;
  logic [15:0]        bitmap_crc;

  logic [15:0]        total;
  logic [7:0]         comp;
  logic [7:0]         page;
  logic [15:0]        width;
  logic [15:0]        height;
  logic [15:0]        fnum;
  logic [7:0]         pbyte;
  logic               pend;

  logic                     accept;
  logic                     start;
  logic                     is_seg_cmd;
  logic                     new_frame;
  logic [ilfb_pkg::PC_W-1:0] entry;
  logic [SEEN_W-1:0]        limit;
  logic                     room;
  logic [7:0]               byte_sel;
  logic                     payload_step;
  ilfb_pkg::seq_cond_t      cond;
  ilfb_pkg::seq_ctl_t       ctl;

  assign in_stall  = ctl.busy;
  assign cfg_ready = !ctl.busy;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    is_seg_cmd = (cmd == ilfb_pkg::CMD_SEGMENT);
    new_frame  = !in_frame || (open_seg != is_seg_cmd);
    start      = 1'b0;
    entry      = ilfb_pkg::A_WAKE;
    case (cmd)
      ilfb_pkg::CMD_WAKE: begin
        start = accept;
        entry = ilfb_pkg::A_WAKE;
      end
      ilfb_pkg::CMD_REFRESH: begin
        start = accept;
        entry = ilfb_pkg::A_REF;
      end
      ilfb_pkg::CMD_PARAMS: begin
        start = accept;
        entry = ilfb_pkg::A_PAR;
      end
      ilfb_pkg::CMD_DATA: begin
        start = accept;
        entry = new_frame ? ilfb_pkg::A_DHDR : ilfb_pkg::A_PAY;
      end
      ilfb_pkg::CMD_SEGMENT: begin
        start = accept;
        entry = new_frame ? ilfb_pkg::A_SHDR : ilfb_pkg::A_PAY;
      end
      default: start = 1'b0;
    endcase
  end

  assign limit = open_seg ? BITMAP_LIMIT : DATA_LIMIT;
  assign room  = seen < limit;

  always_comb begin
    cond.end_flag = pend;
    cond.is_data  = !open_seg;
    cond.room     = room;
    cond.out_free = !out_valid || !out_stall;
  end

  ilfb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .entry (entry),
    .cond  (cond),
    .ctl   (ctl)
  );

  assign payload_step = ctl.word.pay || ctl.word.pad;

  always_comb begin
    case (ctl.word.src)
      ilfb_pkg::SRC_CONST:   byte_sel = ctl.word.konst;
      ilfb_pkg::SRC_LID0:    byte_sel = label_id[7:0];
      ilfb_pkg::SRC_LID1:    byte_sel = label_id[15:8];
      ilfb_pkg::SRC_LID2:    byte_sel = label_id[23:16];
      ilfb_pkg::SRC_LID3:    byte_sel = label_id[31:24];
      ilfb_pkg::SRC_SUB:     byte_sel = data_subcommand;
      ilfb_pkg::SRC_TOT_HI:  byte_sel = total[15:8];
      ilfb_pkg::SRC_TOT_LO:  byte_sel = total[7:0];
      ilfb_pkg::SRC_COMP:    byte_sel = comp;
      ilfb_pkg::SRC_PAGE:    byte_sel = page;
      ilfb_pkg::SRC_W_HI:    byte_sel = width[15:8];
      ilfb_pkg::SRC_W_LO:    byte_sel = width[7:0];
      ilfb_pkg::SRC_H_HI:    byte_sel = height[15:8];
      ilfb_pkg::SRC_H_LO:    byte_sel = height[7:0];
      ilfb_pkg::SRC_FN_HI:   byte_sel = fnum[15:8];
      ilfb_pkg::SRC_FN_LO:   byte_sel = fnum[7:0];
      ilfb_pkg::SRC_PAY:     byte_sel = pbyte;
      ilfb_pkg::SRC_BCRC_LO: byte_sel = bitmap_crc[7:0];
      ilfb_pkg::SRC_BCRC_HI: byte_sel = bitmap_crc[15:8];
      ilfb_pkg::SRC_FCRC_LO: byte_sel = frame_crc[7:0];
      ilfb_pkg::SRC_FCRC_HI: byte_sel = frame_crc[15:8];
      default:               byte_sel = ilfb_pkg::B_ZERO;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      label_id        <= ilfb_pkg::LABEL_ID_RST;
      crc_init        <= ilfb_pkg::CRC_INIT_RST;
      crc_polynomial  <= ilfb_pkg::CRC_POLY_RST;
      data_subcommand <= ilfb_pkg::DATA_SUB_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ilfb_pkg::REG_LABEL_ID:  label_id        <= cfg_data;
        ilfb_pkg::REG_CRC_INIT:  crc_init        <= cfg_data[15:0];
        ilfb_pkg::REG_CRC_POLY:  crc_polynomial  <= cfg_data[15:0];
        ilfb_pkg::REG_DATA_SUB:  data_subcommand <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      total  <= total_count;
      comp   <= compression_kind;
      page   <= page_number;
      width  <= image_width;
      height <= image_height;
      fnum   <= frame_number;
      pbyte  <= payload_byte;
      pend   <= payload_end;
    end
  end

  // frame state and crc registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      open_seg   <= 1'b0;
      seen       <= '0;
      frame_crc  <= ilfb_pkg::CRC_INIT_RST;
      bitmap_crc <= ilfb_pkg::CRC_INIT_RST;
    end else if (start) begin
      if (cmd == ilfb_pkg::CMD_DATA || cmd == ilfb_pkg::CMD_SEGMENT) begin
        if (new_frame) begin
          in_frame   <= 1'b1;
          open_seg   <= is_seg_cmd;
          seen       <= '0;
          frame_crc  <= crc_init;
          bitmap_crc <= crc_init;
        end
      end else begin
        in_frame  <= 1'b0;
        open_seg  <= 1'b0;
        seen      <= '0;
        frame_crc <= crc_init;
      end
    end else if (ctl.emit) begin
      if (ctl.word.crc) begin
        frame_crc <= ilfb_pkg::crc_byte(frame_crc, byte_sel, crc_polynomial);
      end
      if (payload_step) begin
        seen <= seen + 1'b1;
        if (open_seg) begin
          bitmap_crc <= ilfb_pkg::crc_byte(bitmap_crc, byte_sel, crc_polynomial);
        end
      end
      if (ctl.word.close) begin
        in_frame <= 1'b0;
        open_seg <= 1'b0;
        seen     <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      frame_byte <= byte_sel;
      frame_end  <= ctl.word.last;
    end
  end

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    seen <= limit)
    else $error("payload count past frame payload size");

  a_last_ends_program: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && ctl.word.last |=> !ctl.busy && !in_frame)
    else $error("program still running after final crc byte");

  a_seg_needs_frame: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> !open_seg && seen == '0)
    else $error("segment kind or payload count left over outside a frame");

endmodule

// File: sim/tb_ir_label_frame_builder.sv
// tb_ir_label_frame_builder: self-checking testbench for the ir label frame builder
// predicts every wire byte and frame end per item transfer, drives random idle and stall
// depends on ilfb_pkg and ir_label_frame_builder
`timescale 1ns / 1ps

module tb_ir_label_frame_builder;

  localparam int DATA_MAX     = ilfb_pkg::DATA_BYTES_DEF;
  localparam int SEG_LEN      = ilfb_pkg::BITMAP_BYTES_DEF;
  localparam int FILL_LEN     = 22;
  localparam int PARAM_GAP    = 6;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [ilfb_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd4;
  localparam logic [ilfb_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic        drain;
    logic [2:0]  cmd;
    logic [15:0] total_count;
    logic [7:0]  compression_kind;
    logic [7:0]  page_number;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] frame_number;
    logic [7:0]  payload_byte;
    logic        payload_end;
  } ir_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } wire_byte_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic [15:0] total_count = '0;
  logic [7:0] compression_kind = '0;
  logic [7:0] page_number = '0;
  logic [15:0] image_width = '0;
  logic [15:0] image_height = '0;
  logic [15:0] frame_number = '0;
  logic [7:0] payload_byte = '0;
  logic payload_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ilfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ir_item_t   pending_items[$];
  wire_byte_t expected_bytes[$];
  ir_item_t   held;
  wire_byte_t got;
  logic       idle_on = 1'b1;
  int         errors = 0;
  int         checked = 0;
  int         cycles = 0;

  // predictor registers and frame state
  logic [31:0] m_label = ilfb_pkg::LABEL_ID_RST;
  logic [15:0] m_crc_init = ilfb_pkg::CRC_INIT_RST;
  logic [15:0] m_poly = ilfb_pkg::CRC_POLY_RST;
  logic [7:0]  m_sub = ilfb_pkg::DATA_SUB_RST;
  logic        m_open = 1'b0;
  logic [2:0]  m_kind = '0;
  int          m_count = 0;
  logic [15:0] m_fcrc = ilfb_pkg::CRC_INIT_RST;
  logic [15:0] m_bcrc = ilfb_pkg::CRC_INIT_RST;

  ir_label_frame_builder dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ m_poly;
    end
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    expected_bytes.push_back('{b, 1'b0});
    m_fcrc = crc_next(m_fcrc, b);
  endtask

  task automatic put_run(input logic [7:0] b, input int n);
    for (int i = 0; i < n; i++) put_byte(b);
  endtask

  task automatic put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_header(input logic [7:0] proto, input logic [7:0] op);
    m_fcrc = m_crc_init;
    put_byte(proto);
    put_byte(m_label[7:0]);
    put_byte(m_label[15:8]);
    put_byte(m_label[23:16]);
    put_byte(m_label[31:24]);
    put_byte(op);
  endtask

  task automatic put_mcu(input logic [7:0] sub);
    put_header(ilfb_pkg::B_PROTO_MCU, ilfb_pkg::B_OP_MCU);
    put_run(ilfb_pkg::B_ZERO, 3);
    put_byte(sub);
  endtask

  task automatic put_payload(input logic [7:0] b);
    put_byte(b);
    if (m_kind == ilfb_pkg::CMD_SEGMENT) m_bcrc = crc_next(m_bcrc, b);
    m_count++;
  endtask

  task automatic put_fcs();
    expected_bytes.push_back('{m_fcrc[7:0], 1'b0});
    expected_bytes.push_back('{m_fcrc[15:8], 1'b1});
  endtask

  task automatic predict_frame_bytes(input ir_item_t it);
    int lim;
    if (it.cmd > ilfb_pkg::CMD_SEGMENT) return;
    if (it.cmd <= ilfb_pkg::CMD_PARAMS) begin
      m_open = 1'b0;
      m_kind = '0;
      m_count = 0;
      case (it.cmd)
        ilfb_pkg::CMD_WAKE: begin
          put_header(ilfb_pkg::B_PROTO_MCU, ilfb_pkg::B_OP_WAKE);
          put_byte(ilfb_pkg::B_ONE);
          put_run(ilfb_pkg::B_ZERO, 3);
          put_run(ilfb_pkg::B_ONE, FILL_LEN);
        end
        ilfb_pkg::CMD_REFRESH: begin
          put_mcu(ilfb_pkg::B_SUB_REF);
          put_run(ilfb_pkg::B_ZERO, FILL_LEN);
        end
        default: begin
          put_mcu(ilfb_pkg::B_SUB_PAR);
          put_word(it.total_count);
          put_byte(ilfb_pkg::B_ZERO);
          put_byte(it.compression_kind);
          put_byte(it.page_number);
          put_word(it.image_width);
          put_word(it.image_height);
          put_run(ilfb_pkg::B_ZERO, PARAM_GAP);
          put_byte(ilfb_pkg::B_PAR_MARK);
          put_run(ilfb_pkg::B_ZERO, PARAM_GAP);
        end
      endcase
      put_fcs();
      return;
    end
    if (!m_open || m_kind != it.cmd) begin
      m_open = 1'b1;
      m_kind = it.cmd;
      m_count = 0;
      m_bcrc = m_crc_init;
      if (it.cmd == ilfb_pkg::CMD_DATA) begin
        put_mcu(m_sub);
        put_word(it.frame_number);
      end else begin
        put_header(ilfb_pkg::B_PROTO_SEG, ilfb_pkg::B_OP_SEG);
        put_run(ilfb_pkg::B_ZERO, 3);
      end
    end
    lim = (it.cmd == ilfb_pkg::CMD_DATA) ? DATA_MAX : SEG_LEN;
    if (m_count < lim) put_payload(it.payload_byte);
    if (it.payload_end) begin
      while (m_count < lim) put_payload(ilfb_pkg::B_ZERO);
      if (it.cmd == ilfb_pkg::CMD_SEGMENT) begin
        put_byte(m_bcrc[7:0]);
        put_byte(m_bcrc[15:8]);
        put_run(ilfb_pkg::B_ZERO, 2);
        put_byte(ilfb_pkg::B_TRL_A);
        put_byte(ilfb_pkg::B_ZERO);
        put_byte(ilfb_pkg::B_TRL_B);
        put_byte(ilfb_pkg::B_ZERO);
        put_byte(ilfb_pkg::B_TRL_C);
      end
      put_fcs();
      m_open = 1'b0;
      m_kind = '0;
      m_count = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic ir_item_t rand_item(input logic [2:0] c, input logic e);
    ir_item_t it;
    it.drain = 1'b0;
    it.cmd = c;
    it.total_count = 16'($urandom);
    it.compression_kind = 8'($urandom);
    it.page_number = 8'($urandom);
    it.image_width = 16'($urandom);
    it.image_height = 16'($urandom);
    it.frame_number = 16'($urandom);
    it.payload_byte = 8'($urandom);
    it.payload_end = e;
    return it;
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_frame_bytes(held);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0
            && !(pending_items[0].drain && expected_bytes.size() != 0)
            && !(idle_on && $urandom_range(99) < 24)) begin
          held = pending_items.pop_front();
          in_valid <= 1'b1;
          cmd <= held.cmd;
          total_count <= held.total_count;
          compression_kind <= held.compression_kind;
          page_number <= held.page_number;
          image_width <= held.image_width;
          image_height <= held.image_height;
          frame_number <= held.frame_number;
          payload_byte <= held.payload_byte;
          payload_end <= held.payload_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end %0b", frame_byte, frame_end));
        end else begin
          got = expected_bytes.pop_front();
          if (frame_byte !== got.b)
            report_mismatch($sformatf("byte %0d: frame_byte %02h, expected %02h",
                                      checked, frame_byte, got.b));
          if (frame_end !== got.e)
            report_mismatch($sformatf("byte %0d: frame_end %0b, expected %0b",
                                      checked, frame_end, got.e));
        end
        checked++;
      end
      out_stall <= idle_on && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_ir_label_frame_builder: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [ilfb_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ilfb_pkg::REG_LABEL_ID: m_label = val;
      ilfb_pkg::REG_CRC_INIT: m_crc_init = val[15:0];
      ilfb_pkg::REG_CRC_POLY: m_poly = val[15:0];
      ilfb_pkg::REG_DATA_SUB: m_sub = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random(input int n);
    int made;
    int pick;
    int len;
    int lim;
    logic broken;
    logic [2:0] c;
    ir_item_t it;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        it = rand_item(3'($urandom_range(2)), 1'($urandom_range(1)));
        it.drain = ($urandom_range(19) == 0);
        pending_items.push_back(it);
        made++;
      end else if (pick < 92) begin
        c = (pick < 55) ? ilfb_pkg::CMD_DATA : ilfb_pkg::CMD_SEGMENT;
        lim = (c == ilfb_pkg::CMD_DATA) ? DATA_MAX : SEG_LEN;
        len = $urandom_range(lim + 3, 1);
        broken = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
          it = rand_item(c, (k == len - 1) && !broken);
          if (k == 0) it.drain = ($urandom_range(19) == 0);
          pending_items.push_back(it);
          made++;
        end
      end else begin
        pending_items.push_back(rand_item(3'($urandom_range(7, 5)), 1'($urandom_range(1))));
        made++;
      end
    end
  endtask

  initial begin
    ir_item_t it;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // whole frames, params items at the field extremes
    pending_items.push_back(rand_item(ilfb_pkg::CMD_WAKE, 1'b0));
    it = rand_item(ilfb_pkg::CMD_REFRESH, 1'b1);
    it.drain = 1'b1;
    pending_items.push_back(it);
    it = '0;
    it.cmd = ilfb_pkg::CMD_PARAMS;
    pending_items.push_back(it);
    it = '1;
    it.cmd = ilfb_pkg::CMD_PARAMS;
    it.drain = 1'b0;
    pending_items.push_back(it);
    // data frame closed on its first byte
    it = rand_item(ilfb_pkg::CMD_DATA, 1'b1);
    it.frame_number = '1;
    it.payload_byte = '1;
    pending_items.push_back(it);
    // data frame overrun, extra bytes dropped
    for (int k = 0; k < DATA_MAX + 2; k++) begin
      it = rand_item(ilfb_pkg::CMD_DATA, k == DATA_MAX + 1);
      if (k == 0) it.payload_byte = '0;
      pending_items.push_back(it);
    end
    // short segment frame
    pending_items.push_back(rand_item(ilfb_pkg::CMD_SEGMENT, 1'b0));
    pending_items.push_back(rand_item(ilfb_pkg::CMD_SEGMENT, 1'b1));
    // data frame abandoned by a segment byte
    pending_items.push_back(rand_item(ilfb_pkg::CMD_DATA, 1'b0));
    pending_items.push_back(rand_item(ilfb_pkg::CMD_SEGMENT, 1'b1));
    // segment frame abandoned by a whole frame
    pending_items.push_back(rand_item(ilfb_pkg::CMD_SEGMENT, 1'b0));
    pending_items.push_back(rand_item(ilfb_pkg::CMD_WAKE, 1'b0));
    // unknown commands, also inside an open data frame
    pending_items.push_back(rand_item(3'd5, 1'b1));
    pending_items.push_back(rand_item(3'd6, 1'b0));
    pending_items.push_back(rand_item(ilfb_pkg::CMD_DATA, 1'b0));
    pending_items.push_back(rand_item(3'd7, 1'b1));
    pending_items.push_back(rand_item(ilfb_pkg::CMD_DATA, 1'b0));
    settle();

    // registers change while a data frame is still open
    write_reg(ilfb_pkg::REG_LABEL_ID, 32'hFFFF_FFFF);
    write_reg(ilfb_pkg::REG_CRC_INIT, 32'h0000_0000);
    write_reg(ilfb_pkg::REG_CRC_POLY, 32'h0000_FFFF);
    write_reg(ilfb_pkg::REG_DATA_SUB, 32'h0000_00FF);
    write_reg(REG_UNUSED_LO, $urandom);
    write_reg(REG_UNUSED_HI, $urandom);
    @(negedge clk);
    pending_items.push_back(rand_item(ilfb_pkg::CMD_DATA, 1'b1));
    queue_random(20);
    settle();

    write_reg(ilfb_pkg::REG_LABEL_ID, 32'h0000_0000);
    write_reg(ilfb_pkg::REG_CRC_INIT, 32'h0000_FFFF);
    write_reg(ilfb_pkg::REG_CRC_POLY, 32'h0000_0000);
    write_reg(ilfb_pkg::REG_DATA_SUB, 32'h0000_0000);
    @(negedge clk);
    queue_random(15);
    settle();

    // no idle or stall on either side
    write_reg(ilfb_pkg::REG_LABEL_ID, $urandom);
    write_reg(ilfb_pkg::REG_CRC_INIT, $urandom);
    write_reg(ilfb_pkg::REG_CRC_POLY, $urandom);
    write_reg(ilfb_pkg::REG_DATA_SUB, $urandom);
    @(negedge clk);
    idle_on = 1'b0;
    queue_random(30);
    settle();
    idle_on = 1'b1;

    write_reg(ilfb_pkg::REG_LABEL_ID, $urandom);
    write_reg(ilfb_pkg::REG_CRC_INIT, {16'h0000, ilfb_pkg::CRC_INIT_RST});
    write_reg(ilfb_pkg::REG_CRC_POLY, {16'h0000, ilfb_pkg::CRC_POLY_RST});
    write_reg(ilfb_pkg::REG_DATA_SUB, $urandom);
    @(negedge clk);
    queue_random(55);
    settle();

    if (errors == 0) begin
      $display("tb_ir_label_frame_builder: clean");
    end else begin
      $display("tb_ir_label_frame_builder: errors");
    end
    $finish;
  end

endmodule
